/* rtl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants and types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int HUE_W      = 9;
	localparam int CH_W       = 8;
	localparam int FRAC_W     = 6;
	localparam int SECTOR_W   = 4;
	localparam int NUM_W      = 14;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 24;

	localparam int SECTOR_DEG = 60;
	localparam int FULL_SCALE = 255;
	localparam int BIG_SCALE  = FULL_SCALE * SECTOR_DEG;

	// Reciprocal of 60 for the sector, exact for every 9-bit hue.
	localparam int HUE_RECIP   = 1093;
	localparam int HUE_SHIFT   = 16;
	localparam int HUE_PROD_W  = 20;

	// Reciprocal of 255, exact for every product below 65026.
	localparam int P_RECIP     = 65794;
	localparam int P_RECIP_W   = 17;
	localparam int P_SHIFT     = 24;
	localparam int P_PROD_W    = 16;

	// Reciprocal of 15300, exact for every product below 3901501.
	localparam int Q_RECIP     = 4491470;
	localparam int Q_RECIP_W   = 23;
	localparam int Q_SHIFT     = 36;
	localparam int Q_PROD_W    = 22;

	typedef logic [SECTOR_W-1:0] sector_t;
	typedef logic [CH_W-1:0]     channel_t;

	localparam sector_t SECTOR_RED_YELLOW    = 4'd0;
	localparam sector_t SECTOR_YELLOW_GREEN  = 4'd1;
	localparam sector_t SECTOR_GREEN_CYAN    = 4'd2;
	localparam sector_t SECTOR_CYAN_BLUE     = 4'd3;
	localparam sector_t SECTOR_BLUE_MAGENTA  = 4'd4;

endpackage

/* rtl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Six-sector HSV to 8-bit RGB conversion in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (hue, saturation, brightness) and
// leave on the m_axis channel (red, green, blue), one result per request.
// The pipeline takes one request every cycle while the receiver is ready.
// From acceptance to m_axis_tvalid a request passes the sector split, the
// numerator products, the brightness products, the reciprocal scaling, and
// the sector routing into the output register.
// All stages advance together whenever the output register is empty or is
// being taken, so s_axis_tready follows m_axis_tready in the same cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and no request is lost or repeated.
// Reset clears every valid bit; the data registers keep their contents.
// A zero saturation yields gray with all channels equal to brightness.
// Hues from 360 to 511 take the routing of the red-magenta sector.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// hue_deg[8:0], saturation[16:9], brightness[24:17], zero pad[31:25]
	input  logic [hsv2rgb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// red[7:0], green[15:8], blue[23:16]
	output logic [hsv2rgb_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import hsv2rgb_pkg::*;

	logic                  adv;
	logic [HUE_W-1:0]      hue_in;
	logic [HUE_PROD_W-1:0] hue_prod;
	sector_t               sector_in;
	logic [HUE_W:0]        sector_base;
	logic [HUE_W:0]        frac_full;

	logic                  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	sector_t               sector_s1, sector_s2, sector_s3, sector_s4;
	logic [FRAC_W-1:0]     frac_s1;
	channel_t              sat_s1;
	channel_t              bri_s1, bri_s2, bri_s3, bri_s4;
	channel_t              num_p_s2;
	logic [NUM_W-1:0]      num_q_s2, num_t_s2;
	logic [P_PROD_W-1:0]   prod_p_s3;
	logic [Q_PROD_W-1:0]   prod_q_s3, prod_t_s3;
	channel_t              lvl_p_s4, lvl_q_s4, lvl_t_s4;
	channel_t              red_s5, green_s5, blue_s5;

	logic [FRAC_W-1:0]           frac_rest;
	logic [NUM_W-1:0]            sf_q, sf_t;
	logic [P_PROD_W+P_RECIP_W-1:0] scaled_p;
	logic [Q_PROD_W+Q_RECIP_W-1:0] scaled_q, scaled_t;
	channel_t                    red_d, green_d, blue_d;

	assign adv           = !valid_s5 || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = {blue_s5, green_s5, red_s5};

	assign hue_in      = s_axis_tdata[HUE_W-1:0];
	assign hue_prod    = HUE_PROD_W'(hue_in) * HUE_PROD_W'(HUE_RECIP);
	assign sector_in   = hue_prod[HUE_SHIFT+SECTOR_W-1:HUE_SHIFT];
	assign sector_base = (HUE_W+1)'(sector_in) * (HUE_W+1)'(SECTOR_DEG);
	assign frac_full   = (HUE_W+1)'(hue_in) - sector_base;

	assign frac_rest = FRAC_W'(SECTOR_DEG) - frac_s1;
	assign sf_q      = NUM_W'(sat_s1) * NUM_W'(frac_s1);
	assign sf_t      = NUM_W'(sat_s1) * NUM_W'(frac_rest);

	assign scaled_p = (P_PROD_W+P_RECIP_W)'(prod_p_s3) *
		(P_PROD_W+P_RECIP_W)'(P_RECIP);
	assign scaled_q = (Q_PROD_W+Q_RECIP_W)'(prod_q_s3) *
		(Q_PROD_W+Q_RECIP_W)'(Q_RECIP);
	assign scaled_t = (Q_PROD_W+Q_RECIP_W)'(prod_t_s3) *
		(Q_PROD_W+Q_RECIP_W)'(Q_RECIP);

	always_comb begin
		case (sector_s4)
			SECTOR_RED_YELLOW: begin
				red_d = bri_s4;   green_d = lvl_t_s4; blue_d = lvl_p_s4;
			end
			SECTOR_YELLOW_GREEN: begin
				red_d = lvl_q_s4; green_d = bri_s4;   blue_d = lvl_p_s4;
			end
			SECTOR_GREEN_CYAN: begin
				red_d = lvl_p_s4; green_d = bri_s4;   blue_d = lvl_t_s4;
			end
			SECTOR_CYAN_BLUE: begin
				red_d = lvl_p_s4; green_d = lvl_q_s4; blue_d = bri_s4;
			end
			SECTOR_BLUE_MAGENTA: begin
				red_d = lvl_t_s4; green_d = lvl_p_s4; blue_d = bri_s4;
			end
			default: begin
				red_d = bri_s4;   green_d = lvl_p_s4; blue_d = lvl_q_s4;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s1 <= sector_in;
			frac_s1   <= frac_full[FRAC_W-1:0];
			sat_s1    <= s_axis_tdata[HUE_W+CH_W-1:HUE_W];
			bri_s1    <= s_axis_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W];

			sector_s2 <= sector_s1;
			bri_s2    <= bri_s1;
			num_p_s2  <= CH_W'(FULL_SCALE) - sat_s1;
			num_q_s2  <= NUM_W'(BIG_SCALE) - sf_q;
			num_t_s2  <= NUM_W'(BIG_SCALE) - sf_t;

			sector_s3 <= sector_s2;
			bri_s3    <= bri_s2;
			prod_p_s3 <= P_PROD_W'(bri_s2) * P_PROD_W'(num_p_s2);
			prod_q_s3 <= Q_PROD_W'(bri_s2) * Q_PROD_W'(num_q_s2);
			prod_t_s3 <= Q_PROD_W'(bri_s2) * Q_PROD_W'(num_t_s2);

			sector_s4 <= sector_s3;
			bri_s4    <= bri_s3;
			lvl_p_s4  <= scaled_p[P_SHIFT+CH_W-1:P_SHIFT];
			lvl_q_s4  <= scaled_q[Q_SHIFT+CH_W-1:Q_SHIFT];
			lvl_t_s4  <= scaled_t[Q_SHIFT+CH_W-1:Q_SHIFT];

			red_s5    <= red_d;
			green_s5  <= green_d;
			blue_s5   <= blue_d;
		end
	end

endmodule

/* rtl/hsv2rgb_checker.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks of the HSV to RGB converter, bound to its top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic [hsv2rgb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [hsv2rgb_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import hsv2rgb_pkg::*;

	logic in_req;
	logic gray_req;

	assign in_req   = s_axis_tvalid && s_axis_tready;
	assign gray_req = in_req && (s_axis_tdata[HUE_W+CH_W-1:HUE_W] == '0);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled result changed or vanished.");

	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("Input ready does not follow the output side.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_req ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
			##1 m_axis_tready |=> m_axis_tvalid)
		else $error("Request did not arrive after five free cycles.");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		gray_req ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
			##1 m_axis_tready |=>
			(m_axis_tdata[CH_W-1:0] == $past(s_axis_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W], 5)) &&
			(m_axis_tdata[2*CH_W-1:CH_W] == m_axis_tdata[CH_W-1:0]) &&
			(m_axis_tdata[3*CH_W-1:2*CH_W] == m_axis_tdata[CH_W-1:0]))
		else $error("Zero saturation did not give gray at brightness.");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
